// File: src/rab_pkg.sv
// rab_pkg: widths, register indexes and the divider step for the ray/box slab test.
// No dependencies.
package rab_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int T_BITS     = (COORD_BITS + FRAC_BITS > 62) ? 62 : COORD_BITS + FRAC_BITS;
  localparam int EXT_BITS   = T_BITS + 1;           // room for the +/- infinity marks
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int DVD_BITS   = COORD_BITS + 1 + FRAC_BITS;
  localparam int REM_BITS   = COORD_BITS + 1;
  localparam int DIV_STEPS  = DVD_BITS;             // one quotient bit per stage
  localparam int AXES       = 3;
  localparam int LANES      = 2 * AXES;             // lanes 0..2: min planes, 3..5: max planes
  localparam int IDX_BITS   = 3;

  typedef enum logic [IDX_BITS-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                         vld;
    logic                         miss;
    logic [AXES-1:0]              dz;
    logic signed [COORD_BITS-1:0] limit;
  } ctl_t;

  typedef struct packed {
    logic [REM_BITS-1:0] rem;
    logic [DVD_BITS-1:0] dvd;
  } div_t;

  // One restoring step: next dividend bit into the remainder, quotient bit out at the bottom.
  function automatic div_t div_step(div_t cur, logic [COORD_BITS-1:0] b);
    logic [REM_BITS-1:0] r2;
    logic                q;
    div_t                res;
    r2 = {cur.rem[REM_BITS-2:0], cur.dvd[DVD_BITS-1]};
    q  = (r2 >= REM_BITS'(b));
    res.rem = q ? (r2 - REM_BITS'(b)) : r2;
    res.dvd = {cur.dvd[DVD_BITS-2:0], q};
    return res;
  endfunction

endpackage

// File: src/ray_aabb_slab_test.sv
// ray_aabb_slab_test: pipelined slab test of one ray against the configured box.
// Depends on rab_pkg.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | origin_x/y/z, dir_x/y/z, distance_limit
//  out_    | output    | out_valid/out_stall | hit
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle while a stall on the output does not hold the pipeline;
// the six dividers each produce one quotient bit per stage.
// Synchronous active-low reset empties the pipeline and clears the box to zero.
// A stall on the output while out_valid is high freezes every stage at once and back-pressures the input.
module ray_aabb_slab_test
  import rab_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_origin_x,
  input  logic signed [COORD_BITS-1:0] in_origin_y,
  input  logic signed [COORD_BITS-1:0] in_origin_z,
  input  logic signed [COORD_BITS-1:0] in_dir_x,
  input  logic signed [COORD_BITS-1:0] in_dir_y,
  input  logic signed [COORD_BITS-1:0] in_dir_z,
  input  logic signed [COORD_BITS-1:0] in_distance_limit,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [IDX_BITS-1:0]          cfg_index,
  input  logic signed [COORD_BITS-1:0] cfg_data
);

  localparam logic signed [T_BITS-1:0]   T_MAX   = {1'b0, {(T_BITS-1){1'b1}}};
  localparam logic signed [T_BITS-1:0]   T_MIN   = {1'b1, {(T_BITS-1){1'b0}}};
  localparam logic signed [EXT_BITS-1:0] EXT_MAX = {1'b0, {T_BITS{1'b1}}};
  localparam logic signed [EXT_BITS-1:0] EXT_MIN = {1'b1, {T_BITS{1'b0}}};

  logic signed [COORD_BITS-1:0] box_lo_r [AXES];
  logic signed [COORD_BITS-1:0] box_hi_r [AXES];
  logic signed [COORD_BITS-1:0] org      [AXES];
  logic signed [COORD_BITS-1:0] dir      [AXES];

  logic en;

  // pre stage
  ctl_t                        pre_ctl_r;
  logic                        pre_miss_nxt;
  logic signed [DIFF_BITS-1:0] pre_diff_r [LANES];
  logic signed [COORD_BITS-1:0] pre_d_r   [AXES];

  // divider stages, entry 0 is the magnitude stage
  ctl_t                  d_ctl_r [DIV_STEPS+1];
  logic [LANES-1:0]      d_neg_r [DIV_STEPS+1];
  div_t                  d_div_r [DIV_STEPS+1][LANES];
  logic [COORD_BITS-1:0] d_b_r   [DIV_STEPS+1][AXES];
  div_t                  d_div_nxt [DIV_STEPS+1][LANES];

  ctl_t                     t_ctl_r;
  logic signed [T_BITS-1:0] t_r [LANES];

  ctl_t                       e_ctl_r;
  logic signed [EXT_BITS-1:0] entry_r;
  logic signed [EXT_BITS-1:0] exit_r;
  logic signed [EXT_BITS-1:0] entry_nxt;
  logic signed [EXT_BITS-1:0] exit_nxt;

  logic out_valid_r;
  logic out_hit_r;

  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign dir[0] = in_dir_x;
  assign dir[1] = in_dir_y;
  assign dir[2] = in_dir_z;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // box registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        box_lo_r[a] <= '0;
        box_hi_r[a] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_X: box_lo_r[0] <= cfg_data;
        REG_MIN_Y: box_lo_r[1] <= cfg_data;
        REG_MIN_Z: box_lo_r[2] <= cfg_data;
        REG_MAX_X: box_hi_r[0] <= cfg_data;
        REG_MAX_Y: box_hi_r[1] <= cfg_data;
        REG_MAX_Z: box_hi_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero direction with the origin outside that slab
  always_comb begin
    pre_miss_nxt = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (dir[a] == '0 && (org[a] < box_lo_r[a] || org[a] > box_hi_r[a]))
        pre_miss_nxt = 1'b1;
    end
  end

  always_comb begin
    for (int j = 0; j <= DIV_STEPS; j++) begin
      for (int l = 0; l < LANES; l++) begin
        d_div_nxt[j][l] = d_div_r[j][l];
      end
    end
    for (int j = 1; j <= DIV_STEPS; j++) begin
      for (int l = 0; l < LANES; l++) begin
        d_div_nxt[j][l] = div_step(d_div_r[j-1][l], d_b_r[j-1][l % AXES]);
      end
    end
  end

  // axes with zero direction take no part; sentinels stand for infinities
  always_comb begin
    logic signed [EXT_BITS-1:0] ta;
    logic signed [EXT_BITS-1:0] tb;
    logic signed [EXT_BITS-1:0] lo;
    logic signed [EXT_BITS-1:0] hi;
    entry_nxt = EXT_MIN;
    exit_nxt  = EXT_MAX;
    for (int a = 0; a < AXES; a++) begin
      ta = EXT_BITS'(t_r[a]);
      tb = EXT_BITS'(t_r[a+AXES]);
      lo = (ta < tb) ? ta : tb;
      hi = (ta < tb) ? tb : ta;
      if (!t_ctl_r.dz[a] && lo > entry_nxt) entry_nxt = lo;
      if (!t_ctl_r.dz[a] && hi < exit_nxt)  exit_nxt  = hi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_ctl_r.vld <= 1'b0;
      for (int j = 0; j <= DIV_STEPS; j++) d_ctl_r[j].vld <= 1'b0;
      t_ctl_r.vld   <= 1'b0;
      e_ctl_r.vld   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else if (en) begin
      // pre: plane offsets and the zero-direction check
      pre_ctl_r.vld   <= in_valid;
      pre_ctl_r.limit <= in_distance_limit;
      pre_ctl_r.miss  <= pre_miss_nxt;
      for (int a = 0; a < AXES; a++) begin
        pre_ctl_r.dz[a] <= (dir[a] == '0);
        pre_diff_r[a]      <= DIFF_BITS'(box_lo_r[a]) - DIFF_BITS'(org[a]);
        pre_diff_r[a+AXES] <= DIFF_BITS'(box_hi_r[a]) - DIFF_BITS'(org[a]);
        pre_d_r[a]         <= dir[a];
      end

      // magnitudes and quotient signs
      d_ctl_r[0] <= pre_ctl_r;
      for (int l = 0; l < LANES; l++) begin
        d_neg_r[0][l]     <= pre_diff_r[l][DIFF_BITS-1] ^ pre_d_r[l % AXES][COORD_BITS-1];
        d_div_r[0][l].rem <= '0;
        d_div_r[0][l].dvd <= {(pre_diff_r[l][DIFF_BITS-1] ? -pre_diff_r[l] : pre_diff_r[l]),
                              {FRAC_BITS{1'b0}}};
      end
      for (int a = 0; a < AXES; a++) begin
        d_b_r[0][a] <= pre_d_r[a][COORD_BITS-1] ? -pre_d_r[a] : pre_d_r[a];
      end

      for (int j = 1; j <= DIV_STEPS; j++) begin
        d_ctl_r[j] <= d_ctl_r[j-1];
        d_neg_r[j] <= d_neg_r[j-1];
        for (int l = 0; l < LANES; l++) d_div_r[j][l] <= d_div_nxt[j][l];
        for (int a = 0; a < AXES; a++) d_b_r[j][a] <= d_b_r[j-1][a];
      end

      // sign and saturate
      t_ctl_r <= d_ctl_r[DIV_STEPS];
      for (int l = 0; l < LANES; l++) begin
        if (|d_div_r[DIV_STEPS][l].dvd[DVD_BITS-1:T_BITS-1])
          t_r[l] <= d_neg_r[DIV_STEPS][l] ? T_MIN : T_MAX;
        else if (d_neg_r[DIV_STEPS][l])
          t_r[l] <= -T_BITS'(d_div_r[DIV_STEPS][l].dvd[T_BITS-2:0]);
        else
          t_r[l] <= T_BITS'(d_div_r[DIV_STEPS][l].dvd[T_BITS-2:0]);
      end

      e_ctl_r <= t_ctl_r;
      entry_r <= entry_nxt;
      exit_r  <= exit_nxt;

      out_valid_r <= e_ctl_r.vld;
      out_hit_r   <= !e_ctl_r.miss && entry_r <= exit_r &&
                     entry_r <= EXT_BITS'(e_ctl_r.limit);
    end
  end

`ifndef SYNTH
  a_miss_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (en && e_ctl_r.vld && e_ctl_r.miss) |=> (out_valid && !out_hit))
    else $error("zero-direction miss produced a hit");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && !t_ctl_r.vld && !pre_ctl_r.vld))
    else $error("pipeline not empty after reset");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(e_ctl_r.vld) && $stable(entry_r) && $stable(t_ctl_r.vld)))
    else $error("pipeline moved while stalled");
`endif

endmodule

// File: tb/tb_ray_aabb_slab_test.sv
// Testbench for ray_aabb_slab_test: rays are checked against a fixed-point slab predictor.
// The box is set through cfg_ and verdicts on out_hit are compared item by item.
// Depends on rab_pkg and the ray_aabb_slab_test RTL.
module tb_ray_aabb_slab_test;
  import rab_pkg::*;

  localparam int    LATENCY  = DIV_STEPS + 5;
  localparam int    WD_LIMIT = 20000;
  localparam longint T_HI    = (64'sd1 <<< (T_BITS - 1)) - 1;
  localparam longint T_LO    = -T_HI - 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t ox, oy, oz;
    coord_t dx, dy, dz;
    coord_t lim;
  } ray_t;

  logic   clk, rst_n;
  logic   in_valid, in_stall;
  coord_t in_origin_x, in_origin_y, in_origin_z;
  coord_t in_dir_x, in_dir_y, in_dir_z, in_distance_limit;
  logic   out_valid, out_stall, out_hit;
  logic   cfg_valid, cfg_ready;
  logic [IDX_BITS-1:0] cfg_index;
  coord_t cfg_data;

  ray_aabb_slab_test uut (.*);

  ray_t   ray_q[$];
  bit     hit_q[$];
  ray_t   cur_ray;
  longint box_lo[3], box_hi[3];
  int     send_idle_pct, stall_pct;
  bit     hold_rays, failed;
  int     quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void add_ray(ray_t ry);
    ray_q.insert(ray_q.size(), ry);
  endfunction

  // Parameter of one plane: exact truncated division, saturating to the t range.
  function automatic longint plane_t(longint num, longint den);
    longint unsigned a, b, q, r, res;
    bit neg;
    int i;
    a   = (num < 0) ? -num : num;
    b   = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    q   = a / b;
    r   = a % b;
    if (q >= (64'd1 << (T_BITS - 1 - FRAC_BITS))) return neg ? T_LO : T_HI;
    res = q;
    for (i = 0; i < FRAC_BITS; i++) begin
      r   = r << 1;
      res = res << 1;
      if (r >= b) begin
        r   = r - b;
        res = res | 64'd1;
      end
    end
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic bit ray_hits(ray_t ry);
    longint org[3], dv[3];
    longint entry, leave, ta, tb, lo, hi;
    bit miss;
    int ax;
    org[0] = ry.ox; org[1] = ry.oy; org[2] = ry.oz;
    dv[0]  = ry.dx; dv[1]  = ry.dy; dv[2]  = ry.dz;
    entry  = 64'sh8000_0000_0000_0000;
    leave  = 64'sh7fff_ffff_ffff_ffff;
    miss   = 1'b0;
    for (ax = 0; ax < AXES; ax++) begin
      if (dv[ax] == 0) begin
        if (org[ax] < box_lo[ax] || org[ax] > box_hi[ax]) miss = 1'b1;
      end else begin
        ta = plane_t(box_lo[ax] - org[ax], dv[ax]);
        tb = plane_t(box_hi[ax] - org[ax], dv[ax]);
        lo = (ta < tb) ? ta : tb;
        hi = (ta < tb) ? tb : ta;
        if (lo > entry) entry = lo;
        if (hi < leave) leave = hi;
      end
    end
    return !miss && entry <= leave && entry <= longint'(ry.lim);
  endfunction

  // Driver: holds the item until accepted, random gaps between items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) hit_q.insert(hit_q.size(), ray_hits(cur_ray));
      if (!in_valid || !in_stall) begin
        if (ray_q.size() > 0 && !hold_rays && $urandom_range(99) >= send_idle_pct) begin
          cur_ray = ray_q.pop_front();
          in_origin_x       <= cur_ray.ox;
          in_origin_y       <= cur_ray.oy;
          in_origin_z       <= cur_ray.oz;
          in_dir_x          <= cur_ray.dx;
          in_dir_y          <= cur_ray.dy;
          in_dir_z          <= cur_ray.dz;
          in_distance_limit <= cur_ray.lim;
          in_valid          <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall, compare each accepted verdict with the oldest expected.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (hit_q.size() == 0) begin
          $error("hit: unexpected item, actual %0b", out_hit);
          failed = 1'b1;
        end else if (hit_q[0] !== out_hit) begin
          $error("hit: expected %0b actual %0b", hit_q[0], out_hit);
          failed = 1'b1;
          void'(hit_q.pop_front());
        end else begin
          void'(hit_q.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("ray_aabb_slab_test test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_BITS-1:0] idx, coord_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx < 3) box_lo[idx] = val;
    else if (idx < 6) box_hi[idx - 3] = val;
  endtask

  task automatic set_box(coord_t x0, coord_t y0, coord_t z0, coord_t x1, coord_t y1, coord_t z1);
    write_reg(REG_MIN_X, x0);
    write_reg(REG_MIN_Y, y0);
    write_reg(REG_MIN_Z, z0);
    write_reg(REG_MAX_X, x1);
    write_reg(REG_MAX_Y, y1);
    write_reg(REG_MAX_Z, z1);
  endtask

  task automatic drain();
    do @(negedge clk); while (ray_q.size() > 0 || in_valid || hit_q.size() > 0);
  endtask

  function automatic coord_t rand_word();
    return coord_t'($urandom);
  endfunction

  // Aimed ray: aimed at a random point of the box, origin offset by up to 2^(sh-1); some dirs perturbed or zeroed.
  function automatic ray_t aimed_ray();
    ray_t ry;
    longint tgt, org, d;
    coord_t o3[3], d3[3];
    int ax, sh;
    sh = $urandom_range(4, 30);
    for (ax = 0; ax < AXES; ax++) begin
      if (box_hi[ax] > box_lo[ax])
        tgt = box_lo[ax] + longint'({$urandom, $urandom} % (box_hi[ax] - box_lo[ax] + 1));
      else
        tgt = box_lo[ax];
      org = tgt + $signed(longint'($urandom_range(0, 2 ** sh))) - (2 ** (sh - 1));
      d   = (tgt - org) >>> $urandom_range(0, 6);
      if ($urandom_range(99) < 10) d = d + $signed(longint'($urandom_range(0, 64))) - 32;
      if ($urandom_range(99) < 12) d = 0;
      o3[ax] = org[COORD_BITS-1:0];
      d3[ax] = d[COORD_BITS-1:0];
    end
    ry.ox = o3[0]; ry.oy = o3[1]; ry.oz = o3[2];
    ry.dx = d3[0]; ry.dy = d3[1]; ry.dz = d3[2];
    case ($urandom_range(3))
      0:       ry.lim = rand_word();
      1:       ry.lim = 32'sh7fff_ffff;
      default: ry.lim = coord_t'($urandom_range(0, 32'h00ff_ffff));
    endcase
    return ry;
  endfunction

  function automatic ray_t noise_ray();
    ray_t ry;
    ry.ox = rand_word(); ry.oy = rand_word(); ry.oz = rand_word();
    ry.dx = rand_word(); ry.dy = rand_word(); ry.dz = rand_word();
    ry.lim = rand_word();
    if ($urandom_range(3) == 0) ry.dy = '0;
    return ry;
  endfunction

  task automatic queue_random(int n);
    repeat (n) begin
      if ($urandom_range(99) < 70) add_ray(aimed_ray());
      else add_ray(noise_ray());
    end
  endtask

  localparam coord_t ONE  = 32'sh0001_0000;
  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam coord_t CMIN = 32'sh8000_0000;

  initial begin
    int ph;
    rst_n = 1'b0;
    in_valid = 1'b0; out_stall = 1'b0; cfg_valid = 1'b0;
    cfg_index = '0; cfg_data = '0;
    in_origin_x = '0; in_origin_y = '0; in_origin_z = '0;
    in_dir_x = '0; in_dir_y = '0; in_dir_z = '0; in_distance_limit = '0;
    send_idle_pct = 0; stall_pct = 0; hold_rays = 1'b0; failed = 1'b0; quiet_cycles = 0;
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = 0;
      box_hi[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset box is a single point at the origin
    add_ray('{'0, '0, '0, '0, '0, '0, '0});
    add_ray('{'0, '0, '0, ONE, '0, '0, CMIN});
    drain();

    set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    add_ray('{-4 * ONE, '0, '0, ONE, '0, '0, CMAX});        // straight in
    add_ray('{-4 * ONE, '0, '0, ONE, '0, '0, ONE});         // beyond limit
    add_ray('{4 * ONE, '0, '0, ONE, '0, '0, CMAX});         // box behind origin
    add_ray('{'0, '0, '0, '0, '0, '0, CMIN});               // all zero dir, inside
    add_ray('{'0, 2 * ONE, '0, ONE, '0, '0, CMAX});         // zero dir, outside
    add_ray('{-ONE, ONE, ONE, '0, '0, '0, '0});             // on the faces
    add_ray('{CMIN, '0, '0, 32'sd1, '0, '0, CMAX});         // saturating t
    add_ray('{CMAX, '0, '0, -32'sd1, '0, '0, CMAX});
    add_ray('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX});
    add_ray('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN});
    add_ray('{-4 * ONE, -3 * ONE, 5 * ONE, ONE, ONE, -ONE, CMAX}); // glancing
    add_ray('{-4 * ONE, 4 * ONE, '0, ONE, ONE, '0, CMAX});  // passes a corner off
    add_ray('{'1, '1, '1, '1, '1, '1, '1});
    drain();

    // swapped corners and the ignored register indexes
    set_box(ONE, -ONE, -ONE, -ONE, ONE, ONE);
    write_reg(3'd6, rand_word());
    write_reg(3'd7, rand_word());
    add_ray('{-4 * ONE, '0, '0, ONE, '0, '0, CMAX});
    add_ray('{'0, '0, '0, '0, ONE, '0, CMAX});
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      case (ph)
        0: set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        1: set_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        2: set_box(rand_word() >>> 4, rand_word() >>> 4, rand_word() >>> 4,
                   (rand_word() >>> 4) + 32'sh0800_0000, (rand_word() >>> 4) + 32'sh0800_0000,
                   (rand_word() >>> 4) + 32'sh0800_0000);
        3: set_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
        4: set_box(3 * ONE, -7 * ONE, '0, 3 * ONE + 1, -7 * ONE, 32'sd5);
        5: set_box(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        6: set_box(-100 * ONE, 2 * ONE, -ONE, -50 * ONE, 40 * ONE, 1000 * ONE);
        default: set_box(CMIN, -ONE, '0, -ONE, CMAX, CMAX);
      endcase
      queue_random(100);
      if (ph == 2) begin
        // let the pipe run dry before sending the rest
        do @(negedge clk); while (ray_q.size() > 0 || in_valid);
        hold_rays = 1'b1;
        do @(negedge clk); while (hit_q.size() > 0);
        hold_rays = 1'b0;
      end
      queue_random(100);
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (!failed && hit_q.size() == 0)
      $display("ray_aabb_slab_test test passed");
    else
      $display("ray_aabb_slab_test test failed");
    $finish;
  end

endmodule
